@@ design/rmfb_pkg.sv @@
`timescale 1ns / 1ps

package rmfb_pkg;

  localparam int PANEL_WIDTH  = 200;
  localparam int PANEL_HEIGHT = 200;
  localparam int PAGE_ROWS    = 200;
  localparam int STORE_BYTES  = 5000;

  // derived widths
  localparam int AW      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int XW      = $clog2(PANEL_WIDTH);
  localparam int YW      = $clog2(PANEL_HEIGHT);
  localparam int ROW_MAX = (PAGE_ROWS > PANEL_HEIGHT) ? PAGE_ROWS : PANEL_HEIGHT;
  localparam int ROW_W   = $clog2(ROW_MAX);
  localparam int POFF_W  = 5 + $clog2(PAGE_ROWS + 1);
  localparam int DW      = ((POFF_W > YW) ? POFF_W : YW) + 1;
  localparam int PROD_W  = ROW_W + $clog2(PANEL_WIDTH + 1);
  localparam int IDX_W   = PROD_W + 1;
  localparam int CFG_IDX_W = 1;

  localparam logic [7:0] BYTE_ONES = 8'hFF;
  localparam logic [7:0] BYTE_ZERO = 8'h00;

  localparam logic [1:0] REQ_DRAW = 2'd0;
  localparam logic [1:0] REQ_FILL = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROTATION = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE     = 1'd1;

  typedef logic [1:0] resp_kind_t;
  localparam resp_kind_t RESP_NONE  = 2'd0;
  localparam resp_kind_t RESP_DRAW  = 2'd1;
  localparam resp_kind_t RESP_READ  = 2'd2;
  localparam resp_kind_t RESP_EMPTY = 2'd3;

  typedef struct packed {
    logic       load;
    logic       calc_addr;
    logic       write_pixel;
    logic       sweep;
    resp_kind_t resp;
  } dp_cmd_t;

  typedef struct packed {
    logic sweep_last;
  } dp_stat_t;

endpackage

@@ design/rmfb_ctrl.sv @@
`timescale 1ns / 1ps

module rmfb_ctrl import rmfb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] in_req_type,
  input  dp_stat_t   stat,
  output dp_cmd_t    cmd,
  output logic       busy
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_ADDR   = 3'd2;
  localparam logic [2:0] S_FETCH  = 3'd3;
  localparam logic [2:0] S_MODIFY = 3'd4;
  localparam logic [2:0] S_RDWAIT = 3'd5;
  localparam logic [2:0] S_RDRESP = 3'd6;
  localparam logic [2:0] S_FILL   = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt       = state_r;
    cmd.load        = 1'b0;
    cmd.calc_addr   = 1'b0;
    cmd.write_pixel = 1'b0;
    cmd.sweep       = 1'b0;
    cmd.resp        = RESP_NONE;
    unique case (state_r)
      S_CLEAR: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          unique case (in_req_type)
            REQ_DRAW: state_nxt = S_ADDR;
            REQ_FILL: state_nxt = S_FILL;
            REQ_READ: state_nxt = S_RDWAIT;
            default:  cmd.resp  = RESP_EMPTY;
          endcase
        end
      end
      S_ADDR: begin
        cmd.calc_addr = 1'b1;
        state_nxt     = S_FETCH;
      end
      S_FETCH: begin
        state_nxt = S_MODIFY;
      end
      S_MODIFY: begin
        cmd.write_pixel = 1'b1;
        cmd.resp        = RESP_DRAW;
        state_nxt       = S_IDLE;
      end
      S_RDWAIT: begin
        state_nxt = S_RDRESP;
      end
      S_RDRESP: begin
        cmd.resp  = RESP_READ;
        state_nxt = S_IDLE;
      end
      S_FILL: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_last) begin
          cmd.resp  = RESP_EMPTY;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

@@ design/rmfb_datapath.sv @@
`timescale 1ns / 1ps

module rmfb_datapath import rmfb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat,
  input  logic [1:0]           in_req_type,
  input  logic signed [10:0]   in_pos_x,
  input  logic signed [10:0]   in_pos_y,
  input  logic [15:0]          in_color,
  input  logic [12:0]          in_byte_index,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [5:0]           cfg_data,
  output logic                 out_valid,
  output logic [7:0]           out_read_data,
  output logic                 out_pixel_written
);

  // configuration
  logic [1:0]        rotation_r;
  logic              paged_r;
  logic [POFF_W-1:0] page_off_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rotation_r <= 2'd0;
      paged_r    <= 1'b0;
      page_off_r <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_ROTATION) begin
        rotation_r <= cfg_data[1:0];
      end else if (cfg_index == CFG_PAGE) begin
        // zero and negative values mean unpaged
        paged_r    <= !cfg_data[5] && (cfg_data[4:0] != 5'd0);
        page_off_r <= POFF_W'(cfg_data[4:0]) * POFF_W'(PAGE_ROWS);
      end
    end
  end

  // clip and rotate the logical coordinate
  logic [10:0]   lw, lh;
  logic          x_ok, y_ok, page_ok;
  logic [9:0]    xu, yu;
  logic [10:0]   wx, wy, hx, hy;
  logic [XW-1:0] px;
  logic [YW-1:0] py;
  logic [DW-1:0] diff;

  always_comb begin
    lw   = rotation_r[0] ? 11'(PANEL_HEIGHT) : 11'(PANEL_WIDTH);
    lh   = rotation_r[0] ? 11'(PANEL_WIDTH)  : 11'(PANEL_HEIGHT);
    x_ok = !in_pos_x[10] && (in_pos_x < lw);
    y_ok = !in_pos_y[10] && (in_pos_y < lh);
    xu   = in_pos_x[9:0];
    yu   = in_pos_y[9:0];
    wx   = 11'(PANEL_WIDTH - 1) - {1'b0, xu};
    wy   = 11'(PANEL_WIDTH - 1) - {1'b0, yu};
    hx   = 11'(PANEL_HEIGHT - 1) - {1'b0, xu};
    hy   = 11'(PANEL_HEIGHT - 1) - {1'b0, yu};
    unique case (rotation_r)
      2'd0: begin px = XW'(xu); py = YW'(yu); end
      2'd1: begin px = XW'(wy); py = YW'(xu); end
      2'd2: begin px = XW'(wx); py = YW'(hy); end
      default: begin px = XW'(yu); py = YW'(hx); end
    endcase
    diff    = DW'(py) - DW'(page_off_r);
    page_ok = !diff[DW-1] && (diff < DW'(PAGE_ROWS));
  end

  // request registers
  logic [XW-1:0]    px_r;
  logic [ROW_W-1:0] row_r;
  logic             color_zero_r;
  logic             ok_r;
  logic [AW-1:0]    addr_r;
  logic [7:0]       fill_val_r;
  logic [AW-1:0]    cnt_r;
  logic [7:0]       rdata_r;

  logic [PROD_W-1:0] prod;
  logic [IDX_W-1:0]  idx;

  always_comb begin
    prod = PROD_W'(row_r) * PROD_W'(PANEL_WIDTH);
    idx  = IDX_W'(px_r >> 3) + IDX_W'(prod >> 3);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px_r         <= px;
      row_r        <= paged_r ? ROW_W'(diff) : ROW_W'(py);
      color_zero_r <= (in_color == 16'd0);
      if (in_req_type == REQ_READ) begin
        addr_r <= AW'(in_byte_index);
        ok_r   <= (32'(in_byte_index) < 32'(STORE_BYTES));
      end else begin
        addr_r <= addr_r;
        ok_r   <= x_ok && y_ok && (!paged_r || page_ok);
      end
    end else if (cmd.calc_addr) begin
      addr_r <= AW'(idx);
      ok_r   <= ok_r && (32'(idx) < 32'(STORE_BYTES));
    end
  end

  // sweep counter for the reset clear and for fills
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      fill_val_r <= BYTE_ZERO;
    end else if (cmd.load) begin
      cnt_r      <= '0;
      fill_val_r <= (in_color == 16'd0) ? BYTE_ONES : BYTE_ZERO;
    end else if (cmd.sweep) begin
      cnt_r <= cnt_r + AW'(1);
    end
  end

  assign stat.sweep_last = (cnt_r == AW'(STORE_BYTES - 1));

  // frame store: one write port, one registered read port
  logic [7:0]    frame_store_r [STORE_BYTES];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [7:0]    mask;

  always_comb begin
    mask      = 8'h80 >> px_r[2:0];
    mem_we    = cmd.sweep || (cmd.write_pixel && ok_r);
    mem_waddr = cmd.sweep ? cnt_r : addr_r;
    if (cmd.sweep) begin
      mem_wdata = fill_val_r;
    end else if (color_zero_r) begin
      mem_wdata = rdata_r | mask;
    end else begin
      mem_wdata = rdata_r & ~mask;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) frame_store_r[mem_waddr] <= mem_wdata;
    rdata_r <= frame_store_r[addr_r];
  end

  // result beat
  logic       out_valid_r;
  logic [7:0] out_read_data_r;
  logic       out_pixel_written_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cmd.resp != RESP_NONE);
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.resp)
      RESP_DRAW: begin
        out_read_data_r     <= BYTE_ZERO;
        out_pixel_written_r <= ok_r;
      end
      RESP_READ: begin
        out_read_data_r     <= ok_r ? ~rdata_r : BYTE_ONES;
        out_pixel_written_r <= 1'b0;
      end
      RESP_EMPTY: begin
        out_read_data_r     <= BYTE_ZERO;
        out_pixel_written_r <= 1'b0;
      end
      default: begin
        out_read_data_r     <= out_read_data_r;
        out_pixel_written_r <= out_pixel_written_r;
      end
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_read_data     = out_read_data_r;
  assign out_pixel_written = out_pixel_written_r;

endmodule

@@ design/rotated_mono_framebuffer.sv @@
`timescale 1ns / 1ps
// Accept to result strobe: a draw computes the byte address, fetches the byte through the
// registered read port and writes it back modified; a read fetches the byte; a fill sweeps the
// store byte-serially; an unused type answers empty. A new request is taken only while idle.
// Reset: synchronous; a clearing pass over every byte of the frame store follows, busy high.
// Config writes are taken at any time; result beats cannot be stalled by the receiver.

module rotated_mono_framebuffer import rmfb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           in_req_type,
  input  logic signed [10:0]   in_pos_x,
  input  logic signed [10:0]   in_pos_y,
  input  logic [15:0]          in_color,
  input  logic [12:0]          in_byte_index,
  output logic                 out_valid,
  output logic [7:0]           out_read_data,
  output logic                 out_pixel_written,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [5:0]           cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  rmfb_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_req_type (in_req_type),
    .stat        (stat),
    .cmd         (cmd),
    .busy        (busy)
  );

  rmfb_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_req_type       (in_req_type),
    .in_pos_x          (in_pos_x),
    .in_pos_y          (in_pos_y),
    .in_color          (in_color),
    .in_byte_index     (in_byte_index),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_read_data     (out_read_data),
    .out_pixel_written (out_pixel_written)
  );

endmodule
